FILE: rtl/core/dfiir_pkg.sv
// Shared types and constants for the direct-form I IIR filter.
// Used by the tap cell, the top level and the port checker; depends on nothing.
package dfiir_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int COEF_W    = 32;
  localparam int FRAC_W    = 28;
  localparam int MAX_ORDER = 3;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  // Seven products of 56 bits each fit well inside 60 bits.
  localparam int ACC_W     = 60;
  localparam int QUOT_W    = ACC_W - FRAC_W;
  localparam int REG_IDX_W = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [QUOT_W-1:0]   quot_t;

  localparam sample_t SAMPLE_MAX = 24'sh7F_FFFF;
  localparam sample_t SAMPLE_MIN = 24'sh80_0000;
  localparam quot_t   QUOT_MAX   = quot_t'(SAMPLE_MAX);
  localparam quot_t   QUOT_MIN   = quot_t'(SAMPLE_MIN);
  localparam acc_t    ROUND_HALF = acc_t'(1) <<< (FRAC_W - 1);

  localparam coef_t   FF_COEF_0_RESET = 32'sh1000_0000;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FF_COEF_0 = 3'd0,
    REG_FF_COEF_1 = 3'd1,
    REG_FF_COEF_2 = 3'd2,
    REG_FF_COEF_3 = 3'd3,
    REG_FB_COEF_1 = 3'd4,
    REG_FB_COEF_2 = 3'd5,
    REG_FB_COEF_3 = 3'd6
  } reg_idx_t;

  typedef struct packed {
    sample_t sample_in;
    logic    trace_start;
  } sample_item_t;

  typedef struct packed {
    sample_t sample_out;
    logic    clipped;
  } result_item_t;

  // What travels down the row of cells with one transaction: the partial sum,
  // the input taps it still needs and whether it restarts the history.
  typedef struct packed {
    logic                     trace;
    acc_t                     sum;
    sample_t [MAX_ORDER:0]    taps;
  } stage_t;

endpackage

FILE: rtl/core/direct_form_iir_filter.sv
// Top level of the direct-form I IIR filter: coefficient registers, histories,
// the row of tap cells and the output register. Depends on dfiir_pkg and dfiir_cell.
//
// Samples arrive on the sample channel (sample_valid, sample_stall, sample) and
// filtered results leave on the result channel (result_valid, result_stall,
// result), one result per sample, in order. A transaction completes at a rising
// edge with valid high and stall low.
// The first cell multiplies the new sample by b0; the following cells handle the
// taps from ORDER down to one, each adding b_k*x[n-k] - a_k*y[n-k] to the running
// sum. The last cell rounds and saturates, and its output feeds the next sample's
// last cell, so that loop through one multiplier and one add sets the rate.
// A result passes through the register of every cell and then the output register.
// Throughput is one sample per cycle while the receiver does not stall.
// When the receiver stalls, the output register holds its result and the cells
// behind it fill up; sample_stall rises only when every cell is occupied.
// Synchronous reset empties the pipeline, zeroes both histories and loads the
// coefficient defaults (b0 = 1.0, all others zero). Coefficients are written
// through cfg_write, cfg_index and cfg_data while no transaction is in flight.
module direct_form_iir_filter #(
  parameter int ORDER = 3
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  dfiir_pkg::sample_item_t              sample,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output dfiir_pkg::result_item_t              result,
  input  logic                                 cfg_write,
  input  logic [dfiir_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [dfiir_pkg::COEF_W-1:0]         cfg_data
);

  localparam int NCELL = ORDER + 1;
  localparam int LAST  = NCELL - 1;

  dfiir_pkg::coef_t   ff_coef [0:dfiir_pkg::MAX_ORDER];
  dfiir_pkg::coef_t   fb_coef [1:dfiir_pkg::MAX_ORDER];
  dfiir_pkg::sample_t x_hist  [ORDER];
  dfiir_pkg::sample_t y_hist  [ORDER];

  logic [NCELL:0]     free;
  logic [NCELL-1:0]   cell_valid;
  dfiir_pkg::stage_t  cell_stage [NCELL];
  dfiir_pkg::stage_t  cell_next  [NCELL];
  dfiir_pkg::stage_t  entry;

  dfiir_pkg::acc_t    rounded;
  dfiir_pkg::quot_t   quot;
  dfiir_pkg::sample_t y_new;
  logic               clip_new;
  logic               accept;
  logic               produce;

  // Coefficient registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ff_coef[0] <= dfiir_pkg::FF_COEF_0_RESET;
      for (int k = 1; k <= dfiir_pkg::MAX_ORDER; k++) begin
        ff_coef[k] <= '0;
        fb_coef[k] <= '0;
      end
    end else if (cfg_write) begin
      case (cfg_index)
        dfiir_pkg::REG_FF_COEF_0: ff_coef[0] <= cfg_data;
        dfiir_pkg::REG_FF_COEF_1: ff_coef[1] <= cfg_data;
        dfiir_pkg::REG_FF_COEF_2: ff_coef[2] <= cfg_data;
        dfiir_pkg::REG_FF_COEF_3: ff_coef[3] <= cfg_data;
        dfiir_pkg::REG_FB_COEF_1: fb_coef[1] <= cfg_data;
        dfiir_pkg::REG_FB_COEF_2: fb_coef[2] <= cfg_data;
        dfiir_pkg::REG_FB_COEF_3: fb_coef[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Flow control: a cell may load when it is empty or its content moves on.
  assign free[NCELL] = !result_valid || !result_stall;
  for (genvar p = 0; p < NCELL; p++) begin : g_free
    assign free[p] = !cell_valid[p] || free[p+1];
  end
  assign sample_stall = !free[0];
  assign accept       = sample_valid && free[0];
  assign produce      = cell_valid[LAST] && free[NCELL];

  // The new transaction picks up its input taps here; a trace start zeroes all but the new sample.
  always_comb begin
    entry       = '0;
    entry.trace = sample.trace_start;
    entry.taps[0] = sample.sample_in;
    for (int k = 1; k <= ORDER; k++) begin
      entry.taps[k] = sample.trace_start ? '0 : x_hist[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ORDER; k++) begin
        x_hist[k] <= '0;
      end
    end else if (accept) begin
      x_hist[0] <= sample.sample_in;
      for (int k = 1; k < ORDER; k++) begin
        x_hist[k] <= sample.trace_start ? '0 : x_hist[k-1];
      end
    end
  end

  for (genvar p = 0; p < NCELL; p++) begin : g_cell
    localparam int K = (p == 0) ? 0 : NCELL - p;

    dfiir_pkg::stage_t  stage_in;
    logic               valid_in;
    dfiir_pkg::coef_t   b_coef;
    dfiir_pkg::coef_t   a_coef;
    dfiir_pkg::sample_t fb_sample;

    if (p == 0) begin : g_head
      assign stage_in  = entry;
      assign valid_in  = sample_valid;
      assign a_coef    = '0;
      assign fb_sample = '0;
    end else begin : g_tap
      logic [1:0] ahead;
      logic       clr;

      assign stage_in = cell_next[p-1];
      assign valid_in = cell_valid[p-1];
      assign a_coef   = fb_coef[K];

      // Transactions further down the row have not yet written their outputs
      // into the history, so the wanted output sits that many places nearer.
      always_comb begin
        ahead     = '0;
        clr       = cell_stage[p].trace;
        fb_sample = '0;
        for (int q = p + 1; q < NCELL; q++) begin
          if (cell_valid[q]) begin
            ahead = ahead + 2'd1;
            clr   = clr | cell_stage[q].trace;
          end
        end
        for (int j = 0; j < ORDER; j++) begin
          if (int'(ahead) == K - 1 - j) begin
            fb_sample = y_hist[j];
          end
        end
        if (clr) begin
          fb_sample = '0;
        end
      end
    end

    assign b_coef = ff_coef[K];

    dfiir_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .load      (free[p]),
      .valid_in  (valid_in),
      .stage_in  (stage_in),
      .ff_coef   (b_coef),
      .ff_sample (cell_stage[p].taps[K]),
      .fb_coef   (a_coef),
      .fb_sample (fb_sample),
      .valid     (cell_valid[p]),
      .stage     (cell_stage[p]),
      .stage_out (cell_next[p])
    );
  end

  // Round half up to an integer, then saturate to the sample range.
  always_comb begin
    rounded  = cell_next[LAST].sum + dfiir_pkg::ROUND_HALF;
    quot     = rounded[dfiir_pkg::ACC_W-1:dfiir_pkg::FRAC_W];
    clip_new = 1'b0;
    y_new    = quot[dfiir_pkg::SAMPLE_W-1:0];
    if (quot > dfiir_pkg::QUOT_MAX) begin
      y_new    = dfiir_pkg::SAMPLE_MAX;
      clip_new = 1'b1;
    end else if (quot < dfiir_pkg::QUOT_MIN) begin
      y_new    = dfiir_pkg::SAMPLE_MIN;
      clip_new = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (free[NCELL]) begin
      result_valid <= cell_valid[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (free[NCELL]) begin
      result.sample_out <= y_new;
      result.clipped    <= clip_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ORDER; k++) begin
        y_hist[k] <= '0;
      end
    end else if (produce) begin
      y_hist[0] <= y_new;
      for (int k = 1; k < ORDER; k++) begin
        y_hist[k] <= cell_stage[LAST].trace ? '0 : y_hist[k-1];
      end
    end
  end

endmodule

FILE: rtl/core/dfiir_cell.sv
// One tap cell of the filter: a pipeline register and a multiply-accumulate.
// Depends on dfiir_pkg for the stage record and the sample and coefficient types.
module dfiir_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              valid_in,
  input  dfiir_pkg::stage_t stage_in,
  input  dfiir_pkg::coef_t  ff_coef,
  input  dfiir_pkg::sample_t ff_sample,
  input  dfiir_pkg::coef_t  fb_coef,
  input  dfiir_pkg::sample_t fb_sample,
  output logic              valid,
  output dfiir_pkg::stage_t stage,
  output dfiir_pkg::stage_t stage_out
);

  dfiir_pkg::prod_t prod_ff;
  dfiir_pkg::prod_t prod_fb;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage <= stage_in;
    end
  end

  always_comb begin
    prod_ff   = dfiir_pkg::prod_t'(ff_coef) * dfiir_pkg::prod_t'(ff_sample);
    prod_fb   = dfiir_pkg::prod_t'(fb_coef) * dfiir_pkg::prod_t'(fb_sample);
    stage_out = stage;
    stage_out.sum = stage.sum + dfiir_pkg::acc_t'(prod_ff) - dfiir_pkg::acc_t'(prod_fb);
  end

endmodule

FILE: rtl/core/dfiir_checker.sv
// Port-level checks for the direct-form I IIR filter, bound to its top level.
// Depends on dfiir_pkg and on the port list of direct_form_iir_filter.
module dfiir_checker #(
  parameter int ORDER = 3
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            sample_valid,
  input logic                            sample_stall,
  input dfiir_pkg::sample_item_t         sample,
  input logic                            result_valid,
  input logic                            result_stall,
  input dfiir_pkg::result_item_t         result,
  input logic                            cfg_write,
  input logic [dfiir_pkg::REG_IDX_W-1:0] cfg_index,
  input logic [dfiir_pkg::COEF_W-1:0]    cfg_data
);

  localparam int PEND_W = $clog2(ORDER + 3);

  logic [PEND_W-1:0] pending;
  logic              in_acc;
  logic              out_acc;

  assign in_acc  = sample_valid && !sample_stall;
  assign out_acc = result_valid && !result_stall;

  // Transactions accepted whose results have not yet been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + PEND_W'(in_acc) - PEND_W'(out_acc);
    end
  end

  a_reset_empty : assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid high after reset");

  a_result_hold : assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_clip_extreme : assert property (@(posedge clk) disable iff (rst)
    result_valid && result.clipped |->
      result.sample_out == dfiir_pkg::SAMPLE_MAX ||
      result.sample_out == dfiir_pkg::SAMPLE_MIN)
    else $error("clipped result is not at a rail");

  // Coefficients may only change while the pipeline is empty.
  a_cfg_quiet : assert property (@(posedge clk) disable iff (rst)
    cfg_write |-> pending == '0 && !$isunknown({cfg_index, cfg_data}))
    else $error("coefficient written with a transaction in flight");

  a_no_invented : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pending != '0)
    else $error("result offered with no sample outstanding");

endmodule

bind direct_form_iir_filter dfiir_checker #(.ORDER(ORDER)) u_dfiir_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .sample       (sample),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result),
  .cfg_write    (cfg_write),
  .cfg_index    (cfg_index),
  .cfg_data     (cfg_data)
);
